// ----- src/ipd_pkg.sv -----
// Package for the IPD receive deframer: item types, phase and kind codes,
// and header byte constants. No dependencies.
package ipd_pkg;

    localparam int MAX_PAYLOAD_DEF = 2048;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_I     = 8'h49;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] POS_OPEN_END = 4'd4;
    localparam logic [3:0] POS_LINK_ID  = 4'd7;
    localparam logic [3:0] POS_DIGITS   = 4'd9;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_IGNORE  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_EVENT    = 2'd1,
        KIND_OVERSIZE = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       first_of_response;
    } rx_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] conn_id;
        logic       last;
    } res_item_t;

    function automatic logic [7:0] opening_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CHAR_CR;
            2'd1:    c = CHAR_LF;
            2'd2:    c = CHAR_PLUS;
            default: c = CHAR_I;
        endcase
        return c;
    endfunction

endpackage

// ----- src/ipd_receive_frame_parser_top.sv -----
// IPD receive deframer top level: parses "+IPD,<id>,<len>:" responses
// byte by byte and emits payload bytes and event results. Uses ipd_pkg.
//
// Takes one response byte per cycle, stalling while a result waits on res_ready.
// Each accepted item updates the header parser state and, when it causes a
// result, loads the single output register; rx_ready is high whenever that
// register is empty or being taken in the same cycle. A result appears in
// the cycle after its byte. A response opening other than CR LF '+' 'I' gives one
// kind 1 result; a length above MAX_PAYLOAD gives one kind 2 result; each
// payload byte gives a kind 0 result with last set on the final byte.
module ipd_receive_frame_parser_top
    import ipd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    output logic      rx_ready,
    input  rx_item_t  rx_item,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_item
);

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 2);
    localparam int REM_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int PROD_W = LEN_W + 4;

    phase_t             phase_reg, phase_next;
    logic [3:0]         pos_reg, pos_next;
    logic [7:0]         link_reg, link_next;
    logic [LEN_W-1:0]   acc_reg, acc_next;
    logic               ended_reg, ended_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               res_valid_reg, res_valid_next;
    res_item_t          res_item_reg, res_item_next;

    // view of the state after a new-response restart
    phase_t             cur_phase;
    logic [3:0]         cur_pos;
    logic [7:0]         cur_link;
    logic [LEN_W-1:0]   cur_acc;
    logic               cur_ended;
    logic [REM_W-1:0]   cur_rem;

    logic               accept;
    logic [7:0]         b;
    logic               is_digit;
    logic [PROD_W-1:0]  prod;
    logic               emit;
    res_item_t          emit_item;

    assign accept    = rx_valid && rx_ready;
    assign rx_ready  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;
    assign b         = rx_item.rx_byte;
    assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);

    always_comb
    begin
        if (rx_item.first_of_response)
        begin
            cur_phase = PH_HEADER;
            cur_pos   = '0;
            cur_link  = '0;
            cur_acc   = '0;
            cur_ended = 1'b0;
            cur_rem   = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_pos   = pos_reg;
            cur_link  = link_reg;
            cur_acc   = acc_reg;
            cur_ended = ended_reg;
            cur_rem   = rem_reg;
        end
    end

    // acc * 10 + digit
    assign prod = PROD_W'({cur_acc, 3'b000}) + PROD_W'({cur_acc, 1'b0})
                + PROD_W'(b - CHAR_ZERO);

    // next state
    always_comb
    begin
        phase_next = cur_phase;
        pos_next   = cur_pos;
        link_next  = cur_link;
        acc_next   = cur_acc;
        ended_next = cur_ended;
        rem_next   = cur_rem;
        case (cur_phase)
            PH_HEADER:
            begin
                if (cur_pos < POS_OPEN_END)
                begin
                    if (b != opening_char(cur_pos[1:0]))
                        phase_next = PH_IGNORE;
                    else
                        pos_next = cur_pos + 4'd1;
                end
                else if (cur_pos < POS_DIGITS)
                begin
                    if (cur_pos == POS_LINK_ID)
                        link_next = b - CHAR_ZERO;
                    pos_next = cur_pos + 4'd1;
                end
                else if (b == CHAR_COLON)
                begin
                    if (cur_acc > LEN_W'(MAX_PAYLOAD) || cur_acc == '0)
                        phase_next = PH_IGNORE;
                    else
                    begin
                        rem_next   = REM_W'(cur_acc);
                        phase_next = PH_PAYLOAD;
                    end
                end
                else if (!cur_ended)
                begin
                    if (is_digit)
                    begin
                        // saturate just above the limit
                        if (prod > PROD_W'(MAX_PAYLOAD))
                            acc_next = LEN_W'(MAX_PAYLOAD + 1);
                        else
                            acc_next = LEN_W'(prod);
                    end
                    else
                        ended_next = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                if (cur_rem <= REM_W'(1))
                begin
                    rem_next   = '0;
                    phase_next = PH_IGNORE;
                end
                else
                    rem_next = cur_rem - REM_W'(1);
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase
    end

    // result for this item
    always_comb
    begin
        emit      = 1'b0;
        emit_item = '0;
        case (cur_phase)
            PH_HEADER:
            begin
                if (cur_pos < POS_OPEN_END)
                begin
                    if (b != opening_char(cur_pos[1:0]))
                    begin
                        emit           = 1'b1;
                        emit_item.kind = KIND_EVENT;
                        emit_item.last = 1'b1;
                    end
                end
                else if (cur_pos >= POS_DIGITS && b == CHAR_COLON
                         && cur_acc > LEN_W'(MAX_PAYLOAD))
                begin
                    emit              = 1'b1;
                    emit_item.kind    = KIND_OVERSIZE;
                    emit_item.conn_id = cur_link;
                    emit_item.last    = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                emit                   = 1'b1;
                emit_item.kind         = KIND_DATA;
                emit_item.payload_byte = b;
                emit_item.conn_id      = cur_link;
                emit_item.last         = (cur_rem <= REM_W'(1));
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;
        if (accept)
        begin
            res_valid_next = emit;
            res_item_next  = emit_item;
        end
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            link_reg      <= '0;
            acc_reg       <= '0;
            ended_reg     <= 1'b0;
            rem_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                link_reg  <= link_next;
                acc_reg   <= acc_next;
                ended_reg <= ended_next;
                rem_reg   <= rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for ipd_receive_frame_parser_top: drives response bytes, predicts the
// payload and event results, and checks them in order. Depends on ipd_pkg.
module tb_top;
    import ipd_pkg::*;

    localparam int MAX_LEN = MAX_PAYLOAD_DEF;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      rx_valid = 1'b0;
    logic      rx_ready;
    rx_item_t  rx_item = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_item_t res_item;

    ipd_receive_frame_parser_top #(.MAX_PAYLOAD(MAX_LEN)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Stimulus and expected results
    rx_item_t   rx_pending[$];
    res_item_t  deframed_results[$];
    logic [7:0] frame_buf[$];

    // Parser state as predicted
    phase_t      ph = PH_IDLE;
    logic [3:0]  hdr_pos = '0;
    logic [7:0]  link_sel = '0;
    logic [13:0] len_acc = '0;
    logic        digits_done = 1'b0;
    logic [11:0] left_bytes = '0;

    int   error_count = 0;
    int   bytes_taken = 0;
    int   n_data = 0;
    int   n_event = 0;
    int   n_oversize = 0;
    logic rx_taken = 1'b0;
    int   rx_gap = 0;
    int   rx_calm = 0;
    int   res_stall = 0;
    int   res_calm = 0;

    task automatic report(input string msg);
        if (error_count < 30)
            $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_result(input kind_t k, input logic [7:0] d, input logic [7:0] id,
                                input logic l);
        res_item_t r;
        r.kind = k;
        r.payload_byte = d;
        r.conn_id = id;
        r.last = l;
        deframed_results.push_back(r);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic is_first);
        logic [7:0] open_b;
        int acc;
        if (is_first) begin
            hdr_pos = '0;
            ph = PH_HEADER;
            link_sel = '0;
            len_acc = '0;
            digits_done = 1'b0;
            left_bytes = '0;
        end
        case (ph)
            PH_HEADER: begin
                if (hdr_pos < POS_OPEN_END) begin
                    case (hdr_pos[1:0])
                        2'd0:    open_b = CHAR_CR;
                        2'd1:    open_b = CHAR_LF;
                        2'd2:    open_b = CHAR_PLUS;
                        default: open_b = CHAR_I;
                    endcase
                    if (b != open_b) begin
                        ph = PH_IGNORE;
                        queue_result(KIND_EVENT, 8'h00, 8'h00, 1'b1);
                    end else begin
                        hdr_pos = hdr_pos + 4'd1;
                    end
                end else if (hdr_pos < POS_DIGITS) begin
                    if (hdr_pos == POS_LINK_ID)
                        link_sel = b - CHAR_ZERO;
                    hdr_pos = hdr_pos + 4'd1;
                end else if (b == CHAR_COLON) begin
                    if (int'(len_acc) > MAX_LEN) begin
                        ph = PH_IGNORE;
                        queue_result(KIND_OVERSIZE, 8'h00, link_sel, 1'b1);
                    end else if (len_acc == 0) begin
                        ph = PH_IGNORE;
                    end else begin
                        left_bytes = len_acc[11:0];
                        ph = PH_PAYLOAD;
                    end
                end else if (!digits_done) begin
                    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        acc = int'(len_acc) * 10 + int'(b) - int'(CHAR_ZERO);
                        if (acc > MAX_LEN)
                            acc = MAX_LEN + 1;
                        len_acc = 14'(acc);
                    end else begin
                        digits_done = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                queue_result(KIND_DATA, b, link_sel, left_bytes <= 1);
                if (left_bytes <= 1) begin
                    left_bytes = '0;
                    ph = PH_IGNORE;
                end else begin
                    left_bytes = left_bytes - 12'd1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input res_item_t got);
        res_item_t want;
        case (got.kind)
            KIND_DATA:     n_data++;
            KIND_EVENT:    n_event++;
            KIND_OVERSIZE: n_oversize++;
            default: ;
        endcase
        if (deframed_results.size() == 0) begin
            report($sformatf("unexpected result kind=%0d byte=%02h id=%02h last=%0b",
                             got.kind, got.payload_byte, got.conn_id, got.last));
            return;
        end
        want = deframed_results.pop_front();
        if (got.kind != want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.payload_byte != want.payload_byte)
            report($sformatf("payload_byte %02h, expected %02h",
                             got.payload_byte, want.payload_byte));
        if (got.conn_id != want.conn_id)
            report($sformatf("conn_id %02h, expected %02h", got.conn_id, want.conn_id));
        if (got.last != want.last)
            report($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Feed bytes at the falling edge; hold the item until it is taken
    always @(negedge clk) begin
        if (rst_n) begin
            if (!rx_valid || rx_taken) begin
                if (rx_gap > 0) begin
                    rx_gap--;
                    rx_valid <= 1'b0;
                end else if (rx_pending.size() != 0) begin
                    rx_item <= rx_pending.pop_front();
                    rx_valid <= 1'b1;
                    if ($urandom_range(149) == 0)
                        rx_calm = $urandom_range(200, 50);
                    if (rx_calm > 0) begin
                        rx_calm--;
                        rx_gap = 0;
                    end else begin
                        rx_gap = idle_len();
                    end
                end else begin
                    rx_valid <= 1'b0;
                end
            end
            if (res_stall > 0) begin
                res_stall--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
                if ($urandom_range(149) == 0)
                    res_calm = $urandom_range(200, 50);
                if (res_calm > 0)
                    res_calm--;
                else if ($urandom_range(3) == 0)
                    res_stall = idle_len();
            end
        end
    end

    // Predict on accepted bytes, then check accepted results
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_taken <= 1'b0;
        end else begin
            rx_taken <= rx_valid && rx_ready;
            if (rx_valid && rx_ready) begin
                bytes_taken++;
                predict_byte(rx_item.rx_byte, rx_item.first_of_response);
            end
            if (res_valid && res_ready)
                check_result(res_item);
        end
    end

    task automatic put(input logic [7:0] b);
        frame_buf.push_back(b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    task automatic put_opening();
        put(CHAR_CR);
        put(CHAR_LF);
        put(CHAR_PLUS);
        put(CHAR_I);
    endtask

    task automatic put_payload(input int n);
        repeat (n) put(8'($urandom_range(255)));
    endtask

    task automatic put_ipd_header(input logic [7:0] id_b, input string len_txt);
        put_opening();
        put_text("PD,");
        put(id_b);
        put_text(",");
        put_text(len_txt);
        put(CHAR_COLON);
    endtask

    // Move the buffered bytes to the driver; lead flags byte 0 as a new response
    task automatic send_frame(input bit lead);
        rx_item_t it;
        for (int i = 0; i < frame_buf.size(); i++) begin
            it.rx_byte = frame_buf[i];
            it.first_of_response = lead && (i == 0);
            rx_pending.push_back(it);
        end
        frame_buf.delete();
    endtask

    initial begin
        int random_count;
        int r;
        int n;
        int pay;
        int k;
        int waited;
        logic [7:0] id_b;
        logic [7:0] bad;
        string len_txt;

        // Bytes before any response start are dropped
        put_opening();
        put(CHAR_COLON);
        put(8'hFF);
        send_frame(0);
        // Opening mismatch at each of the four positions
        put(8'h00);
        send_frame(1);
        put(CHAR_CR);
        put_text("x");
        send_frame(1);
        put(CHAR_CR);
        put(CHAR_LF);
        put_text("OK");
        send_frame(1);
        put(CHAR_CR);
        put(CHAR_LF);
        put_text("+CIP");
        send_frame(1);
        // Smallest payload, then raw id byte 0 with trailing bytes
        put_ipd_header("0", "1");
        put(8'hFF);
        send_frame(1);
        put_ipd_header(8'h00, "3");
        put(8'h00);
        put(8'h80);
        put(8'h7F);
        put_text("OK");
        send_frame(1);
        // Zero length, length over limit, saturating digits
        put_ipd_header("1", "0");
        put(8'h55);
        send_frame(1);
        put_ipd_header("2", "2049");
        put_payload(2);
        send_frame(1);
        put_ipd_header("3", "99999999999");
        send_frame(1);
        // Digits end at the first non-digit; later digits are skipped
        put_ipd_header("9", "0012x7");
        put_payload(12);
        send_frame(1);
        // Colons inside the fixed header are ordinary bytes
        put_opening();
        repeat (5) put(CHAR_COLON);
        put_text("5:");
        put_payload(5);
        send_frame(1);
        // Non-digit right at the length field gives zero length
        put_ipd_header("1", ",3");
        put_payload(3);
        send_frame(1);
        // New response in the middle of a payload, then in the middle of a header
        put_ipd_header("2", "8");
        put_payload(3);
        send_frame(1);
        put_opening();
        put_text("PD,2,1");
        send_frame(1);
        // Largest length, cut short by the next response
        put_ipd_header("4", "2048");
        put_payload(40);
        send_frame(1);

        random_count = rx_pending.size();
        while (random_count < 1200) begin
            r = $urandom_range(99);
            if (r < 65) begin
                id_b = ($urandom_range(4) != 0) ? 8'(CHAR_ZERO + $urandom_range(4))
                                                : 8'($urandom_range(255));
                k = $urandom_range(99);
                if (k < 70)
                    n = $urandom_range(16, 1);
                else if (k < 85)
                    n = $urandom_range(80, 17);
                else if (k < 90)
                    n = $urandom_range(300, 81);
                else if (k < 95)
                    n = 0;
                else
                    n = $urandom_range(99999, MAX_LEN + 1);
                len_txt = $sformatf("%0d", n);
                if ($urandom_range(4) == 0)
                    len_txt = {"00", len_txt};
                if ($urandom_range(5) == 0)
                    len_txt = {len_txt, "x", $sformatf("%0d", $urandom_range(9))};
                put_ipd_header(id_b, len_txt);
                pay = (n >= 1 && n <= MAX_LEN) ? n : 0;
                if (pay > 0 && $urandom_range(9) == 0)
                    pay = $urandom_range(pay - 1);
                if ($urandom_range(19) == 0) begin
                    k = $urandom_range(frame_buf.size() - 1, 1);
                    while (frame_buf.size() > k)
                        void'(frame_buf.pop_back());
                    pay = 0;
                end
                put_payload(pay);
                random_count += frame_buf.size();
                send_frame(1);
                if ($urandom_range(4) == 0) begin
                    put_payload($urandom_range(4, 1));
                    send_frame(0);
                end
            end else if (r < 80) begin
                // Break the opening at a random position
                k = $urandom_range(3);
                put_opening();
                bad = frame_buf[k];
                while (frame_buf.size() > k)
                    void'(frame_buf.pop_back());
                n = $urandom_range(255);
                put((8'(n) == bad) ? ~bad : 8'(n));
                random_count += frame_buf.size();
                put_payload($urandom_range(6));
                send_frame(1);
            end else if (r < 90) begin
                put_payload($urandom_range(12, 1));
                random_count += frame_buf.size();
                send_frame(1);
            end else if (r < 95) begin
                // Stray bytes continue whatever response is in progress
                put_payload($urandom_range(5, 1));
                random_count += frame_buf.size();
                send_frame(0);
            end else begin
                put_opening();
                repeat (5) put(($urandom_range(1) != 0) ? CHAR_COLON : 8'($urandom_range(255)));
                n = $urandom_range(9, 1);
                put_text($sformatf("%0d", n));
                put(CHAR_COLON);
                put_payload(n);
                random_count += frame_buf.size();
                send_frame(1);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (rx_pending.size() != 0 || rx_valid)
            @(posedge clk);
        waited = 0;
        while (deframed_results.size() != 0 && waited < 200000) begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (deframed_results.size() != 0)
            report($sformatf("%0d expected results never came", deframed_results.size()));

        $display("sent %0d response bytes through the deframer", bytes_taken);
        $display("checked %0d payload, %0d event and %0d oversize results",
                 n_data, n_event, n_oversize);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
src/ipd_pkg.sv
src/ipd_receive_frame_parser_top.sv
sim/tb_top.sv
